FILE: sv/bipms_pkg.sv
// Package for the bound-IP register machine step core.
// Holds opcode and config index codes, stream payload layouts and widths.
// No dependencies.
`default_nettype none

package bipms_pkg;

    localparam int DATA_W       = 32;
    localparam int NUM_OUT_REGS = 6;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_WDATA_W  = 7;
    localparam int IN_TDATA_W   = 72;
    localparam int OUT_TDATA_W  = 232;
    localparam int IN_FIELDS_W  = 71;
    localparam int OUT_FIELDS_W = 225;

    localparam logic [2:0] IP_BINDING_RST     = 3'd0;
    localparam logic [6:0] PROGRAM_LENGTH_RST = 7'd64;

    typedef enum logic [3:0] {
        OP_ADDR, OP_ADDI, OP_MULR, OP_MULI,
        OP_BANR, OP_BANI, OP_BORR, OP_BORI,
        OP_SETR, OP_SETI, OP_GTIR, OP_GTRI,
        OP_GTRR, OP_EQIR, OP_EQRI, OP_EQRR
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IP_BINDING,
        CFG_PROGRAM_LENGTH
    } cfg_index_t;

    // Last member sits in the lowest bits: matches the s_tdata layout.
    typedef struct packed {
        logic [2:0]               dest_index;
        logic signed [DATA_W-1:0] operand_b;
        logic signed [DATA_W-1:0] operand_a;
        opcode_t                  opcode;
    } instr_t;

    typedef struct packed {
        logic [2:0] ip_binding;
        logic [6:0] program_length;
    } cfg_t;

    typedef struct packed {
        logic                     halted;
        logic signed [DATA_W-1:0] next_ip;
    } exec_status_t;

endpackage

`default_nettype wire

FILE: sv/bipms_exec.sv
// Single-pass execute logic: IP copy, operand read, ALU, write-back, next IP.
// Purely combinational. Depends on bipms_pkg.
`default_nettype none

module bipms_exec #(
    parameter int NUM_REGS      = 6,
    parameter int PROGRAM_DEPTH = 64
) (
    input  bipms_pkg::instr_t                          instr,
    input  logic [NUM_REGS-1:0][bipms_pkg::DATA_W-1:0] rf,
    input  logic [bipms_pkg::DATA_W-1:0]               ip,
    input  bipms_pkg::cfg_t                            cfg,
    output logic [NUM_REGS-1:0][bipms_pkg::DATA_W-1:0] rf_next,
    output bipms_pkg::exec_status_t                    status
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DW    = bipms_pkg::DATA_W;

    logic [DW-1:0]              bind_ext;
    logic [DW-1:0]              dest_ext;
    logic                       bind_ok;
    logic                       a_ok;
    logic                       b_ok;
    logic                       dest_ok;
    logic [IDX_W-1:0]           bidx;
    logic [IDX_W-1:0]           aidx;
    logic [IDX_W-1:0]           bidx_b;
    logic [IDX_W-1:0]           didx;
    logic [NUM_REGS-1:0][DW-1:0] rf_ip;
    logic signed [DW-1:0]       ra;
    logic signed [DW-1:0]       rb;
    logic signed [DW-1:0]       src_b;
    logic [DW-1:0]              sum;
    logic [DW-1:0]              prod;
    logic [DW-1:0]              res;
    logic [DW-1:0]              nxt;
    logic [DW-1:0]              plen;
    logic [DW-1:0]              depth;
    logic [DW-1:0]              len;

    assign bind_ext = DW'(cfg.ip_binding);
    assign dest_ext = DW'(instr.dest_index);
    assign bind_ok  = bind_ext < DW'(NUM_REGS);
    assign dest_ok  = dest_ext < DW'(NUM_REGS);
    // negative operands compare as huge unsigned values and read zero
    assign a_ok     = $unsigned(instr.operand_a) < DW'(NUM_REGS);
    assign b_ok     = $unsigned(instr.operand_b) < DW'(NUM_REGS);
    assign bidx     = bind_ext[IDX_W-1:0];
    assign didx     = dest_ext[IDX_W-1:0];
    assign aidx     = instr.operand_a[IDX_W-1:0];
    assign bidx_b   = instr.operand_b[IDX_W-1:0];

    // pointer copy into the bound register, then operand select
    always_comb
    begin
        ra = '0;
        rb = '0;
        for (int j = 0; j < NUM_REGS; j++)
        begin
            rf_ip[j] = (bind_ok && bidx == IDX_W'(j)) ? ip : rf[j];
        end
        for (int j = 0; j < NUM_REGS; j++)
        begin
            if (a_ok && aidx == IDX_W'(j))
            begin
                ra = rf_ip[j];
            end
            if (b_ok && bidx_b == IDX_W'(j))
            begin
                rb = rf_ip[j];
            end
        end
    end

    // opcodes 0..7: odd codes take the immediate as second operand
    assign src_b = instr.opcode[0] ? instr.operand_b : rb;
    assign sum   = ra + src_b;
    assign prod  = ra * src_b;

    always_comb
    begin
        unique case (instr.opcode)
            bipms_pkg::OP_ADDR, bipms_pkg::OP_ADDI: res = sum;
            bipms_pkg::OP_MULR, bipms_pkg::OP_MULI: res = prod;
            bipms_pkg::OP_BANR, bipms_pkg::OP_BANI: res = ra & src_b;
            bipms_pkg::OP_BORR, bipms_pkg::OP_BORI: res = ra | src_b;
            bipms_pkg::OP_SETR: res = ra;
            bipms_pkg::OP_SETI: res = instr.operand_a;
            bipms_pkg::OP_GTIR: res = {{(DW-1){1'b0}}, instr.operand_a > rb};
            bipms_pkg::OP_GTRI: res = {{(DW-1){1'b0}}, ra > instr.operand_b};
            bipms_pkg::OP_GTRR: res = {{(DW-1){1'b0}}, ra > rb};
            bipms_pkg::OP_EQIR: res = {{(DW-1){1'b0}}, instr.operand_a == rb};
            bipms_pkg::OP_EQRI: res = {{(DW-1){1'b0}}, ra == instr.operand_b};
            bipms_pkg::OP_EQRR: res = {{(DW-1){1'b0}}, ra == rb};
            default:            res = '0;
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < NUM_REGS; j++)
        begin
            rf_next[j] = (dest_ok && didx == IDX_W'(j)) ? res : rf_ip[j];
        end
    end

    // unbound pointer reads zero, so the next pointer is one
    assign nxt   = bind_ok ? (rf_next[bidx] + DW'(1)) : DW'(1);
    assign plen  = DW'(cfg.program_length);
    assign depth = DW'(PROGRAM_DEPTH);
    assign len   = (plen > depth) ? depth : plen;

    assign status.next_ip = nxt;
    assign status.halted  = nxt[DW-1] || (nxt >= len);

endmodule

`default_nettype wire

FILE: sv/bound_ip_register_machine_step_core.sv
// Top level of the bound-IP register machine step core.
// Input register, execute logic (bipms_exec), state and result register.
// Depends on bipms_pkg and bipms_exec.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  cfg     | in  | cfg_we             | cfg_index, cfg_wdata
//  s       | in  | s_tvalid/s_tready  | s_tdata: opcode, operand_a, operand_b, dest
//  m       | out | m_tvalid/m_tready  | m_tdata: next_ip, halted, reg_zero..reg_five
//
// One instruction per cycle sustained while the m side does not stall; each
// accepted transaction passes the input register, then the result register.
// The register file and pointer update in the same cycle the result loads.
// Reset returns register 0 to one, the rest and the pointer to zero.
// A stalled m side holds one result plus one instruction in the input
// register; s_tready drops only then.
`default_nettype none

module bound_ip_register_machine_step_core #(
    parameter int NUM_REGS      = 6,
    parameter int PROGRAM_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bipms_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bipms_pkg::CFG_WDATA_W-1:0]     cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // opcode[3:0], operand_a[35:4], operand_b[67:36], dest_index[70:68], pad
    input  logic [bipms_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // next_ip[31:0], halted[32], reg_zero[64:33] .. reg_five[224:193], pad
    output logic [bipms_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int DW = bipms_pkg::DATA_W;

    logic                                   in_valid_reg;
    bipms_pkg::instr_t                      instr_reg;
    logic                                   out_valid_reg;
    logic [bipms_pkg::OUT_TDATA_W-1:0]      out_data_reg;
    logic [NUM_REGS-1:0][DW-1:0]            rf_reg;
    logic [NUM_REGS-1:0][DW-1:0]            rf_next;
    logic [DW-1:0]                          ip_reg;
    bipms_pkg::cfg_t                        cfg_reg;
    bipms_pkg::exec_status_t                status;
    logic                                   advance;
    logic [bipms_pkg::NUM_OUT_REGS-1:0][DW-1:0] out_regs;
    logic [bipms_pkg::OUT_TDATA_W-1:0]      out_data_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= {bipms_pkg::IP_BINDING_RST, bipms_pkg::PROGRAM_LENGTH_RST};
        end
        else if (cfg_we)
        begin
            unique case (bipms_pkg::cfg_index_t'(cfg_index))
                bipms_pkg::CFG_IP_BINDING:
                    cfg_reg.ip_binding <= cfg_wdata[2:0];
                bipms_pkg::CFG_PROGRAM_LENGTH:
                    cfg_reg.program_length <= cfg_wdata[6:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            instr_reg <= bipms_pkg::instr_t'(s_tdata[bipms_pkg::IN_FIELDS_W-1:0]);
        end
    end

    bipms_exec #(
        .NUM_REGS      (NUM_REGS),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_exec (
        .instr   (instr_reg),
        .rf      (rf_reg),
        .ip      (ip_reg),
        .cfg     (cfg_reg),
        .rf_next (rf_next),
        .status  (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_reg <= {{(NUM_REGS-1){DW'(0)}}, DW'(1)};
            ip_reg <= '0;
        end
        else if (advance)
        begin
            rf_reg <= rf_next;
            ip_reg <= status.next_ip;
        end
    end

    // result fields for registers the file does not have read zero
    for (genvar j = 0; j < bipms_pkg::NUM_OUT_REGS; j++)
    begin : g_out_regs
        if (j < NUM_REGS)
        begin : g_present
            assign out_regs[j] = rf_next[j];
        end
        else
        begin : g_absent
            assign out_regs[j] = '0;
        end
    end

    assign out_data_next = {
        {(bipms_pkg::OUT_TDATA_W - bipms_pkg::OUT_FIELDS_W){1'b0}},
        out_regs, status.halted, status.next_ip
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bipms_checker.sv
// Port-level checks for the bound-IP register machine step core, bound to
// the top level. Depends on bipms_pkg and bound_ip_register_machine_step_core.
`default_nettype none

module bipms_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bipms_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped under stall");

    // input side stalls only behind a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low without output backpressure");

    // an accepted transaction reaches the output when the output side does not stall
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("result missing after accepted transaction");

    // no result appears without an earlier accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching transaction");

endmodule

bind bound_ip_register_machine_step_core bipms_checker u_bipms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
